>>> rtl/core/ccd_pkg.sv
// shared types, widths and codes for the trilinear drag deposit block
`timescale 1ns / 1ps
package ccd_pkg;

  localparam int GRID_N_DEF = 32;

  localparam int STORE_AW    = 15;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  localparam int Q_W       = 32;
  localparam int SUM_W     = 48;
  localparam int MAG_W     = SUM_W + 1;
  localparam int DIG_W     = 16;
  localparam int MUL_STEPS = 4;
  localparam int UB_W      = DIG_W * MUL_STEPS;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int W_W       = 33;
  localparam int TOT_W     = 52;
  localparam int QUO_W     = 48;
  localparam int VF_W      = 17;
  localparam int CFG_IW    = 3;

  localparam logic [VF_W-1:0]  ONE_Q16  = VF_W'(65536);
  localparam logic [SUM_W-1:0] HALF_Q16 = SUM_W'(32768);
  localparam logic [SUM_W-1:0] POS_LIM  = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] NEG_LIM  = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_OUTSIDE = 2'd1;
  localparam logic [1:0] STS_ZERO_WT = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_INV_DX_X = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INV_DX_Y = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_INV_DX_Z = 3'd5;
  localparam logic [CFG_IW-1:0] CFG_INV_VOL  = 3'd6;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [W_W-1:0]   num;
    logic [TOT_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/core/ccd_mul.sv
// shared unsigned multiplier, one 16-bit digit of b per cycle
`timescale 1ns / 1ps
module ccd_mul (
  input  logic              clk,
  input  logic              rst,
  input  ccd_pkg::mul_req_t req,
  output ccd_pkg::mul_rsp_t rsp
);
  import ccd_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic [MAG_W-1:0]         ua;
  logic [UB_W-1:0]          ub;
  logic [PROD_W-1:0]        acc;
  logic [PROD_W-1:0]        acc_next;
  logic [MAG_W+DIG_W-1:0]   pp;
  logic [CNT_W-1:0]         cnt;
  logic                     run;
  logic                     done;

  // high digit first, shift the partial sum up each step
  assign pp       = ua * ub[UB_W-1 -: DIG_W];
  assign acc_next = {acc[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + PROD_W'(pp);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
        ua  <= req.a;
        ub  <= UB_W'(req.b);
        acc <= '0;
      end else if (run) begin
        acc <= acc_next;
        ub  <= {ub[UB_W-DIG_W-1:0], {DIG_W{1'b0}}};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule

>>> rtl/core/ccd_div.sv
// restoring divider, one quotient bit per cycle, for the weight normalization
`timescale 1ns / 1ps
module ccd_div (
  input  logic              clk,
  input  logic              rst,
  input  ccd_pkg::div_req_t req,
  output ccd_pkg::div_rsp_t rsp
);
  import ccd_pkg::*;

  localparam int CNT_W = $clog2(QUO_W);

  logic [TOT_W-1:0] rem;
  logic [TOT_W-1:0] den;
  logic [QUO_W-1:0] sh;
  logic [QUO_W-1:0] quo;
  logic [TOT_W:0]   rem2;
  logic [TOT_W:0]   diff;
  logic             ge;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             done;

  assign rem2 = {rem, sh[QUO_W-1]};
  assign diff = rem2 - {1'b0, den};
  assign ge   = rem2 >= {1'b0, den};

  // dividend is num shifted up by 32; top part of it is already below den
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= TOT_W'(req.num[W_W-1:DIG_W]);
        sh  <= {req.num[DIG_W-1:0], {(QUO_W-DIG_W){1'b0}}};
        den <= req.den;
        quo <= '0;
      end else if (run) begin
        rem <= ge ? diff[TOT_W-1:0] : rem2[TOT_W-1:0];
        sh  <= {sh[QUO_W-2:0], 1'b0};
        quo <= {quo[QUO_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QUO_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

>>> rtl/core/cut_cell_trilinear_particle_deposit_unit.sv
// top level: command decode, sequencer, cell stores and deposit datapath
// load and clear go from idle straight to the result; a read passes READ1 and READ2 first
// deposit: multiplies run through the shared 4-step multiplier; maps the position, weighs
//   the neighbours and forms beta, then per uncovered neighbour divides (skipped when the
//   weight saturates), multiplies and accumulates, and last posts the result
// throughput: one item at a time, in_ready only in idle; the next item follows the result
// reset: synchronous, clears control and config; then a clearing pass over every store entry
//   zeroes the accumulators, in_ready stays low meanwhile (config writes are still taken)
`timescale 1ns / 1ps
module cut_cell_trilinear_particle_deposit_unit #(
  parameter int GRID_NX = ccd_pkg::GRID_N_DEF,
  parameter int GRID_NY = ccd_pkg::GRID_N_DEF,
  parameter int GRID_NZ = ccd_pkg::GRID_N_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccd_pkg::CFG_IW-1:0]         cfg_index,
  input  logic [ccd_pkg::Q_W-1:0]            cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         cmd,
  input  logic signed [ccd_pkg::Q_W-1:0]     pos_x,
  input  logic signed [ccd_pkg::Q_W-1:0]     pos_y,
  input  logic signed [ccd_pkg::Q_W-1:0]     pos_z,
  input  logic signed [ccd_pkg::Q_W-1:0]     drag_coef,
  input  logic signed [ccd_pkg::Q_W-1:0]     vel_x,
  input  logic signed [ccd_pkg::Q_W-1:0]     vel_y,
  input  logic signed [ccd_pkg::Q_W-1:0]     vel_z,
  input  logic [ccd_pkg::STORE_AW-1:0]       cell_index,
  input  logic [ccd_pkg::VF_W-1:0]           vol_frac_in,
  input  logic                               covered_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic signed [ccd_pkg::SUM_W-1:0]   sum_x,
  output logic signed [ccd_pkg::SUM_W-1:0]   sum_y,
  output logic signed [ccd_pkg::SUM_W-1:0]   sum_z,
  output logic signed [ccd_pkg::SUM_W-1:0]   sum_beta
);
  import ccd_pkg::*;

  // sequencer codes
  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_READ1   = 4'd2;
  localparam logic [3:0] ST_READ2   = 4'd3;
  localparam logic [3:0] ST_MAP     = 4'd4;
  localparam logic [3:0] ST_WXY     = 4'd5;
  localparam logic [3:0] ST_WZ      = 4'd6;
  localparam logic [3:0] ST_VF      = 4'd7;
  localparam logic [3:0] ST_BETA    = 4'd8;
  localparam logic [3:0] ST_BV      = 4'd9;
  localparam logic [3:0] ST_NEXT    = 4'd10;
  localparam logic [3:0] ST_DIV     = 4'd11;
  localparam logic [3:0] ST_CONTRIB = 4'd12;
  localparam logic [3:0] ST_ACC     = 4'd13;
  localparam logic [3:0] ST_DONE    = 4'd14;

  localparam int ACC_W = 4 * SUM_W;
  localparam int GEO_W = VF_W + 1;

  // grid sizes folded into the store index width (flat index wraps with the store)
  localparam logic [STORE_AW-1:0] NX_S = STORE_AW'(GRID_NX);
  localparam logic [STORE_AW-1:0] NY_S = STORE_AW'(GRID_NY);
  localparam logic [W_W-1:0] NX_M1 = W_W'(GRID_NX - 1);
  localparam logic [W_W-1:0] NY_M1 = W_W'(GRID_NY - 1);
  localparam logic [W_W-1:0] NZ_M1 = W_W'(GRID_NZ - 1);

  // (p >> 16) with magnitude saturation to the signed 48-bit range
  function automatic logic signed [SUM_W-1:0] qsat(input logic [PROD_W-1:0] p,
                                                   input logic neg);
    logic [PROD_W-DIG_W-1:0] full;
    logic [SUM_W-1:0]        lim;
    logic [SUM_W-1:0]        mag;
    full = p[PROD_W-1:DIG_W];
    lim  = neg ? NEG_LIM : POS_LIM;
    mag  = (full > (PROD_W-DIG_W)'(lim)) ? lim : full[SUM_W-1:0];
    return $signed(neg ? (~mag + 1'b1) : mag);
  endfunction

  function automatic logic [MAG_W-1:0] mag48(input logic [SUM_W-1:0] x);
    logic [MAG_W-1:0] e;
    e = {x[SUM_W-1], x};
    return e[MAG_W-1] ? (~e + 1'b1) : e;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) return s[SUM_W] ? NEG_LIM : POS_LIM;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic [VF_W-1:0] wsel(input logic [DIG_W-1:0] f, input logic hi);
    return hi ? {1'b0, f} : (ONE_Q16 - {1'b0, f});
  endfunction

  // configuration registers
  logic [Q_W-1:0] origin_x, origin_y, origin_z;
  logic [Q_W-1:0] inv_dx_x, inv_dx_y, inv_dx_z, inv_cell_vol;

  // sequencer state and counters
  logic [3:0]          state;
  logic [STORE_AW-1:0] clr_cnt;
  logic [1:0]          ax;
  logic [2:0]          n;
  logic [1:0]          k;
  logic                mwait;

  // latched item
  logic [1:0]          cmd_r;
  logic [Q_W-1:0]      pos_r   [3];
  logic [Q_W-1:0]      vel_r   [3];
  logic [Q_W-1:0]      drag_r;
  logic [STORE_AW-1:0] cell_r;

  // per-deposit working set
  logic [STORE_AW-1:0] coord   [3];
  logic [DIG_W-1:0]    frac    [3];
  logic [W_W-1:0]      w_arr   [8];
  logic [STORE_AW-1:0] idx_arr [8];
  logic                cov_arr [8];
  logic [MAG_W-1:0]    mtmp;
  logic [W_W-1:0]      wcur;
  logic [TOT_W-1:0]    total;
  logic [TOT_W-1:0]    total_next;
  logic [SUM_W-1:0]    beta;
  logic [SUM_W-1:0]    bv      [3];
  logic [QUO_W-1:0]    nw;
  logic [SUM_W-1:0]    contrib [4];

  // result staging and output register
  logic [1:0]          res_status;
  logic [ACC_W-1:0]    res_sums;

  // stores
  logic [GEO_W-1:0]    geo_mem [STORE_DEPTH];
  logic [GEO_W-1:0]    geo_q;
  logic [ACC_W-1:0]    acc_mem [STORE_DEPTH];
  logic [ACC_W-1:0]    acc_q;
  logic                acc_we;
  logic [STORE_AW-1:0] acc_wa;
  logic [ACC_W-1:0]    acc_wd;
  logic [STORE_AW-1:0] acc_ra;

  mul_req_t mreq;
  mul_rsp_t mrsp;
  div_req_t dreq;
  div_rsp_t drsp;
  logic     mneg;
  logic     mul_state;

  logic               in_fire;
  logic [Q_W-1:0]     pos_sel, org_sel, inv_sel;
  logic [W_W-1:0]     nm1_sel;
  logic [W_W-1:0]     diff;
  logic [MAG_W-1:0]   xq;
  logic [W_W-1:0]     cell_hi;
  logic [STORE_AW-1:0] ii, jj, kk, idx_cur;
  logic [SUM_W-1:0]   csel;
  logic               w_sat;
  logic [VF_W-1:0]    vf_clip;
  logic signed [SUM_W-1:0] qres;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // config writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      origin_z     <= '0;
      inv_dx_x     <= Q_W'(ONE_Q16);
      inv_dx_y     <= Q_W'(ONE_Q16);
      inv_dx_z     <= Q_W'(ONE_Q16);
      inv_cell_vol <= Q_W'(ONE_Q16);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X: origin_x     <= cfg_data;
        CFG_ORIGIN_Y: origin_y     <= cfg_data;
        CFG_ORIGIN_Z: origin_z     <= cfg_data;
        CFG_INV_DX_X: inv_dx_x     <= cfg_data;
        CFG_INV_DX_Y: inv_dx_y     <= cfg_data;
        CFG_INV_DX_Z: inv_dx_z     <= cfg_data;
        CFG_INV_VOL:  inv_cell_vol <= cfg_data;
        default: ;
      endcase
    end
  end

  // axis selection for the position map
  always_comb begin
    unique case (ax)
      2'd0: begin
        pos_sel = pos_r[0]; org_sel = origin_x; inv_sel = inv_dx_x; nm1_sel = NX_M1;
      end
      2'd1: begin
        pos_sel = pos_r[1]; org_sel = origin_y; inv_sel = inv_dx_y; nm1_sel = NY_M1;
      end
      default: begin
        pos_sel = pos_r[2]; org_sel = origin_z; inv_sel = inv_dx_z; nm1_sel = NZ_M1;
      end
    endcase
  end

  // exact 33-bit difference; a negative one lies below the grid
  assign diff    = {pos_sel[Q_W-1], pos_sel} - {org_sel[Q_W-1], org_sel};
  // scaled position plus half a cell: integer part is the cell, fraction the hi weight
  assign xq      = {1'b0, mrsp.p[Q_W+DIG_W+DIG_W-1:DIG_W]} + {1'b0, HALF_Q16};
  assign cell_hi = xq[MAG_W-1:DIG_W];

  // neighbour n = {a,b,c} sits at (i-1+a, j-1+b, k-1+c)
  assign ii      = coord[0] - 1'b1 + STORE_AW'(n[2]);
  assign jj      = coord[1] - 1'b1 + STORE_AW'(n[1]);
  assign kk      = coord[2] - 1'b1 + STORE_AW'(n[0]);
  assign idx_cur = ii + STORE_AW'(NX_S * STORE_AW'(jj + STORE_AW'(NY_S * kk)));

  assign csel  = (k == 2'd3) ? beta : bv[k];
  // quotient would reach 2^16: normalized weight saturates without dividing
  assign w_sat = ((TOT_W+DIG_W)'(w_arr[n]) >= {total, {DIG_W{1'b0}}});
  assign total_next = total + mrsp.p[TOT_W-1:0];
  assign vf_clip = (vol_frac_in > ONE_Q16) ? ONE_Q16 : vol_frac_in;

  // shared multiplier operand selection
  always_comb begin
    mreq.a    = '0;
    mreq.b    = '0;
    mneg      = 1'b0;
    mul_state = 1'b1;
    case (state)
      ST_MAP: begin
        mreq.a = MAG_W'(diff[Q_W-1:0]);
        mreq.b = MAG_W'(inv_sel);
      end
      ST_WXY: begin
        mreq.a = MAG_W'(wsel(frac[0], n[2]));
        mreq.b = MAG_W'(wsel(frac[1], n[1]));
      end
      ST_WZ: begin
        mreq.a = mtmp;
        mreq.b = MAG_W'(wsel(frac[2], n[0]));
      end
      ST_VF: begin
        mreq.a = MAG_W'(wcur);
        mreq.b = MAG_W'(geo_q[GEO_W-1:1]);
      end
      ST_BETA: begin
        mreq.a = MAG_W'(inv_cell_vol);
        mreq.b = mag48(SUM_W'($signed(drag_r)));
        mneg   = drag_r[Q_W-1];
      end
      ST_BV: begin
        mreq.a = mag48(SUM_W'($signed(vel_r[k])));
        mreq.b = mag48(beta);
        mneg   = vel_r[k][Q_W-1] ^ beta[SUM_W-1];
      end
      ST_CONTRIB: begin
        mreq.a = MAG_W'(nw);
        mreq.b = mag48(csel);
        mneg   = csel[SUM_W-1];
      end
      default: mul_state = 1'b0;
    endcase
  end

  assign mreq.start = mul_state && !mwait && !(state == ST_MAP && diff[W_W-1]);
  assign qres       = qsat(mrsp.p, mneg);

  assign dreq.start = (state == ST_NEXT) && !cov_arr[n] && !w_sat;
  assign dreq.num   = w_arr[n];
  assign dreq.den   = total;

  ccd_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  ccd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // geometry store: volume fraction (clipped to 1.0) and covered flag
  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_LOAD) begin
      geo_mem[cell_index] <= {vf_clip, covered_in};
    end
    geo_q <= geo_mem[idx_cur];
  end

  // accumulator store: one write port shared by clearing pass, clear and deposit
  always_comb begin
    acc_we = 1'b0;
    acc_wa = idx_arr[n];
    acc_wd = '0;
    if (state == ST_CLEAR) begin
      acc_we = 1'b1;
      acc_wa = clr_cnt;
    end else if (in_fire && cmd == CMD_CLEAR) begin
      acc_we = 1'b1;
      acc_wa = cell_index;
    end else if (state == ST_ACC) begin
      acc_we = 1'b1;
      acc_wd = {sat_add(acc_q[4*SUM_W-1 -: SUM_W], contrib[3]),
                sat_add(acc_q[3*SUM_W-1 -: SUM_W], contrib[2]),
                sat_add(acc_q[2*SUM_W-1 -: SUM_W], contrib[1]),
                sat_add(acc_q[SUM_W-1:0],          contrib[0])};
    end
  end

  assign acc_ra = (cmd_r == CMD_READ) ? cell_r : idx_arr[n];

  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_q <= acc_mem[acc_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      ax        <= '0;
      n         <= '0;
      k         <= '0;
      mwait     <= 1'b0;
      out_valid <= 1'b0;
      cmd_r     <= CMD_LOAD;
    end else begin
      if (mreq.start) begin
        mwait <= 1'b1;
      end else if (mrsp.done) begin
        mwait <= 1'b0;
      end
      // output register: load a new result when free or draining, else drop on transfer
      if (state == ST_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == {STORE_AW{1'b1}}) state <= ST_IDLE;
        end

        ST_IDLE: begin
          if (in_fire) begin
            cmd_r      <= cmd;
            pos_r[0]   <= pos_x;
            pos_r[1]   <= pos_y;
            pos_r[2]   <= pos_z;
            vel_r[0]   <= vel_x;
            vel_r[1]   <= vel_y;
            vel_r[2]   <= vel_z;
            drag_r     <= drag_coef;
            cell_r     <= cell_index;
            res_status <= STS_OK;
            res_sums   <= '0;
            ax         <= '0;
            unique case (cmd)
              CMD_DEPOSIT: state <= ST_MAP;
              CMD_READ:    state <= ST_READ1;
              default:     state <= ST_DONE;
            endcase
          end
        end

        ST_READ1: state <= ST_READ2;

        ST_READ2: begin
          res_sums <= acc_q;
          state    <= ST_DONE;
        end

        ST_MAP: begin
          if (!mwait && diff[W_W-1]) begin
            res_status <= STS_OUTSIDE;
            state      <= ST_DONE;
          end else if (mrsp.done) begin
            if (cell_hi == '0 || cell_hi > nm1_sel) begin
              res_status <= STS_OUTSIDE;
              state      <= ST_DONE;
            end else begin
              coord[ax] <= cell_hi[STORE_AW-1:0];
              frac[ax]  <= xq[DIG_W-1:0];
              if (ax == 2'd2) begin
                n     <= '0;
                total <= '0;
                state <= ST_WXY;
              end else begin
                ax <= ax + 1'b1;
              end
            end
          end
        end

        ST_WXY: begin
          if (mrsp.done) begin
            mtmp  <= mrsp.p[MAG_W-1:0];
            state <= ST_WZ;
          end
        end

        ST_WZ: begin
          if (mrsp.done) begin
            w_arr[n] <= mrsp.p[W_W+DIG_W-1:DIG_W];
            wcur     <= mrsp.p[W_W+DIG_W-1:DIG_W];
            state    <= ST_VF;
          end
        end

        // total weight accumulates w * volume fraction, covered cells included
        ST_VF: begin
          if (mrsp.done) begin
            total      <= total_next;
            cov_arr[n] <= geo_q[0];
            idx_arr[n] <= idx_cur;
            if (n == 3'd7) begin
              if (total_next == '0) begin
                res_status <= STS_ZERO_WT;
                state      <= ST_DONE;
              end else begin
                state <= ST_BETA;
              end
            end else begin
              n     <= n + 1'b1;
              state <= ST_WXY;
            end
          end
        end

        ST_BETA: begin
          if (mrsp.done) begin
            beta  <= qres;
            k     <= '0;
            state <= ST_BV;
          end
        end

        ST_BV: begin
          if (mrsp.done) begin
            bv[k] <= qres;
            if (k == 2'd2) begin
              n     <= '0;
              state <= ST_NEXT;
            end else begin
              k <= k + 1'b1;
            end
          end
        end

        // covered neighbours are passed over
        ST_NEXT: begin
          k <= '0;
          if (cov_arr[n]) begin
            if (n == 3'd7) state <= ST_DONE;
            else n <= n + 1'b1;
          end else if (w_sat) begin
            nw    <= {QUO_W{1'b1}};
            state <= ST_CONTRIB;
          end else begin
            state <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (drsp.done) begin
            nw    <= drsp.quo;
            state <= ST_CONTRIB;
          end
        end

        ST_CONTRIB: begin
          if (mrsp.done) begin
            contrib[k] <= qres;
            if (k == 2'd3) state <= ST_ACC;
            else k <= k + 1'b1;
          end
        end

        ST_ACC: begin
          if (n == 3'd7) begin
            state <= ST_DONE;
          end else begin
            n     <= n + 1'b1;
            state <= ST_NEXT;
          end
        end

        ST_DONE: begin
          if (!out_valid || out_ready) begin
            status    <= res_status;
            sum_x     <= res_sums[SUM_W-1:0];
            sum_y     <= res_sums[2*SUM_W-1 -: SUM_W];
            sum_z     <= res_sums[3*SUM_W-1 -: SUM_W];
            sum_beta  <= res_sums[4*SUM_W-1 -: SUM_W];
            cmd_r     <= CMD_LOAD;
            state     <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // no accumulator update ever lands on a covered neighbour
  a_acc_uncovered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC) |-> !cov_arr[n])
    else $error("accumulate on covered cell");

  // clearing pass runs to its end without interruption
  a_clear_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR && clr_cnt != {STORE_AW{1'b1}}) |=> (state == ST_CLEAR))
    else $error("clearing pass cut short");

  // the divider only ever sees a nonzero total weight
  a_div_total: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (total != '0))
    else $error("divide by zero total weight");

  // multiplier results only come back for an issued operation
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> mwait)
    else $error("unexpected multiplier result");

  // a flagged deposit reports zero sums
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != STS_OK) |->
      (sum_x == '0 && sum_y == '0 && sum_z == '0 && sum_beta == '0))
    else $error("nonzero sums on flagged result");

endmodule

>>> sim/cut_cell_trilinear_particle_deposit_unit_tb.sv
// testbench for the trilinear drag deposit unit: directed and random commands checked against a predictor
`timescale 1ns / 1ps
module cut_cell_trilinear_particle_deposit_unit_tb;
  import ccd_pkg::*;

  localparam int     GRID_N      = GRID_N_DEF;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int     HOLD_CYCLES = 4000;
  localparam logic [CFG_IW-1:0] REG_IDX [7] = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z,
    CFG_INV_DX_X, CFG_INV_DX_Y, CFG_INV_DX_Z, CFG_INV_VOL};

  // one input transfer
  typedef struct {
    logic [1:0]                cmd;
    logic signed [Q_W-1:0]     px, py, pz, drag, vx, vy, vz;
    logic [STORE_AW-1:0]       cidx;
    logic [VF_W-1:0]           vf;
    logic                      cov;
  } particle_cmd_t;

  // one output transfer
  typedef struct packed {
    logic [1:0]       status;
    logic [SUM_W-1:0] sx, sy, sz, sb;
  } cell_sums_t;

  // scoreboard: cell stores, registers and the queue of expected sums
  class drag_deposit_scoreboard;
    bit signed [31:0] org [3];
    bit [31:0]        inv [3];
    bit [31:0]        inv_vol;
    longint           acc_x [STORE_DEPTH];
    longint           acc_y [STORE_DEPTH];
    longint           acc_z [STORE_DEPTH];
    longint           acc_b [STORE_DEPTH];
    int               vf_map [STORE_DEPTH];
    bit               cov_map [STORE_DEPTH];
    cell_sums_t       expected_sums [$];
    int               errors;
    int               results_seen;

    function new();
      org = '{0, 0, 0};
      inv = '{65536, 65536, 65536};
      inv_vol = 65536;
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_ORIGIN_X: org[0] = val;
        CFG_ORIGIN_Y: org[1] = val;
        CFG_ORIGIN_Z: org[2] = val;
        CFG_INV_DX_X: inv[0] = val;
        CFG_INV_DX_Y: inv[1] = val;
        CFG_INV_DX_Z: inv[2] = val;
        CFG_INV_VOL:  inv_vol = val;
        default: ;
      endcase
    endfunction

    function longint sat48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return v;
    endfunction

    // fixed-point product, magnitude truncated, saturated to 48 bits
    function longint mulq(longint a, longint b);
      bit         neg;
      bit [63:0]  ua, ub, lim;
      bit [127:0] p;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
      p = (128'(ua) * 128'(ub)) >> 16;
      if (p > 128'(lim)) p = 128'(lim);
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function bit map_axis(logic signed [31:0] p, bit signed [31:0] o, bit [31:0] s,
                          output longint c, output longint f);
      longint     d;
      bit [127:0] pr;
      bit [63:0]  xq;
      d = longint'(p) - longint'(o);
      if (d < 0) return 0;
      pr = 128'(d) * 128'(s);
      xq = {16'd0, pr[63:16]} + 64'h8000;
      c = longint'(xq >> 16);
      f = longint'(xq[15:0]);
      return c >= 1 && c <= GRID_N - 1;
    endfunction

    // the eight neighbour cells and their raw weights; 0 when off the grid
    function bit neighbors(logic signed [31:0] px, py, pz,
                           output int idx [8], output longint w [8]);
      longint ci, cj, ck, fx, fy, fz;
      longint wx [2], wy [2], wz [2];
      int n;
      if (!map_axis(px, org[0], inv[0], ci, fx) || !map_axis(py, org[1], inv[1], cj, fy) ||
          !map_axis(pz, org[2], inv[2], ck, fz))
        return 0;
      wx = '{65536 - fx, fx};
      wy = '{65536 - fy, fy};
      wz = '{65536 - fz, fz};
      for (int a = 0; a < 2; a++)
        for (int b = 0; b < 2; b++)
          for (int c = 0; c < 2; c++) begin
            n = a * 4 + b * 2 + c;
            w[n] = (wx[a] * wy[b] * wz[c]) >>> 16;
            idx[n] = int'((ci - 1 + a + GRID_N * ((cj - 1 + b) + GRID_N * (ck - 1 + c)))
                          & (STORE_DEPTH - 1));
          end
      return 1;
    endfunction

    function logic [1:0] predict_deposit(particle_cmd_t it);
      int         idx [8];
      longint     w [8];
      longint     tot, beta, bvx, bvy, bvz, nw;
      bit [127:0] q;
      int         i;
      if (!neighbors(it.px, it.py, it.pz, idx, w)) return STS_OUTSIDE;
      tot = 0;
      for (int n = 0; n < 8; n++) tot += w[n] * vf_map[idx[n]];
      if (tot == 0) return STS_ZERO_WT;
      beta = mulq(longint'(inv_vol), longint'(it.drag));
      bvx = mulq(longint'(it.vx), beta);
      bvy = mulq(longint'(it.vy), beta);
      bvz = mulq(longint'(it.vz), beta);
      for (int n = 0; n < 8; n++) begin
        i = idx[n];
        if (cov_map[i]) continue;
        if (w[n] / tot >= 65536) begin
          nw = 64'hFFFF_FFFF_FFFF;
        end else begin
          q = (128'(w[n]) << 32) / 128'(tot);
          nw = longint'(q[63:0]);
        end
        acc_x[i] = sat48(acc_x[i] + mulq(nw, bvx));
        acc_y[i] = sat48(acc_y[i] + mulq(nw, bvy));
        acc_z[i] = sat48(acc_z[i] + mulq(nw, bvz));
        acc_b[i] = sat48(acc_b[i] + mulq(nw, beta));
      end
      return STS_OK;
    endfunction

    function void note_item(particle_cmd_t it);
      cell_sums_t r;
      int c;
      r = '0;
      c = int'(it.cidx);
      case (it.cmd)
        CMD_LOAD: begin
          vf_map[c] = (it.vf > ONE_Q16) ? 65536 : int'(it.vf);
          cov_map[c] = it.cov;
        end
        CMD_DEPOSIT: r.status = predict_deposit(it);
        CMD_READ: begin
          r.sx = SUM_W'(acc_x[c]);
          r.sy = SUM_W'(acc_y[c]);
          r.sz = SUM_W'(acc_z[c]);
          r.sb = SUM_W'(acc_b[c]);
        end
        default: begin
          acc_x[c] = 0;
          acc_y[c] = 0;
          acc_z[c] = 0;
          acc_b[c] = 0;
        end
      endcase
      expected_sums.push_back(r);
    endfunction

    function void compare(string field, logic [SUM_W-1:0] e, logic [SUM_W-1:0] g);
      if (g !== e) begin
        errors++;
        $display("%0t mismatch %s expected %h actual %h", $time, field, e, g);
      end
    endfunction

    function void check_result(cell_sums_t got);
      cell_sums_t e;
      results_seen++;
      if (expected_sums.size() == 0) begin
        errors++;
        $display("%0t result with nothing expected, actual %h", $time, got);
        return;
      end
      e = expected_sums.pop_front();
      compare("status", SUM_W'(e.status), SUM_W'(got.status));
      compare("sum_x", e.sx, got.sx);
      compare("sum_y", e.sy, got.sy);
      compare("sum_z", e.sz, got.sz);
      compare("sum_beta", e.sb, got.sb);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IW-1:0]     cfg_index;
  logic [Q_W-1:0]        cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            cmd;
  logic signed [Q_W-1:0] pos_x, pos_y, pos_z, drag_coef, vel_x, vel_y, vel_z;
  logic [STORE_AW-1:0]   cell_index;
  logic [VF_W-1:0]       vol_frac_in;
  logic                  covered_in;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            status;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_z, sum_beta;

  drag_deposit_scoreboard sb = new();
  particle_cmd_t          seen_item;
  bit                     geom_ready [STORE_DEPTH];   // cells whose geometry is already sent
  int                     burst_left;
  longint                 cycle_count;

  cut_cell_trilinear_particle_deposit_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .drag_coef(drag_coef),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .cell_index(cell_index), .vol_frac_in(vol_frac_in), .covered_in(covered_in),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .sum_x(sum_x), .sum_y(sum_y), .sum_z(sum_z), .sum_beta(sum_beta)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // input transfer monitor: predict at acceptance
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      seen_item.cmd = cmd;
      seen_item.px = pos_x;
      seen_item.py = pos_y;
      seen_item.pz = pos_z;
      seen_item.drag = drag_coef;
      seen_item.vx = vel_x;
      seen_item.vy = vel_y;
      seen_item.vz = vel_z;
      seen_item.cidx = cell_index;
      seen_item.vf = vol_frac_in;
      seen_item.cov = covered_in;
      sb.note_item(seen_item);
    end
  end

  // output transfer monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{status, sum_x, sum_y, sum_z, sum_beta});
  end

  // receiver: stall pattern in random modes, plus one long hold-off to back up the block
  initial begin
    int  mode;
    int  mode_left;
    int  hold;
    bit  held;
    mode_left = 0;
    hold = 0;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sb.results_seen >= 300) begin
        held = 1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(2);
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(1);
          default: out_ready <= ($urandom_range(9) == 0);
        endcase
      end
    end
  end

  function automatic particle_cmd_t rand_item();
    particle_cmd_t it;
    it.cmd = 2'($urandom);
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.drag = $urandom;
    it.vx = $urandom;
    it.vy = $urandom;
    it.vz = $urandom;
    it.cidx = STORE_AW'($urandom);
    it.vf = VF_W'($urandom);
    it.cov = 1'($urandom);
    return it;
  endfunction

  function automatic particle_cmd_t cell_item(logic [1:0] c, int cell_id);
    particle_cmd_t it;
    it = rand_item();
    it.cmd = c;
    it.cidx = STORE_AW'(cell_id);
    return it;
  endfunction

  function automatic particle_cmd_t load_item(int cell_id, int vf, bit cov);
    particle_cmd_t it;
    it = cell_item(CMD_LOAD, cell_id);
    it.vf = VF_W'(vf);
    it.cov = cov;
    return it;
  endfunction

  function automatic particle_cmd_t deposit_item(int px, int py, int pz, int drag,
                                                 int vx, int vy, int vz);
    particle_cmd_t it;
    it = rand_item();
    it.cmd = CMD_DEPOSIT;
    it.px = px;
    it.py = py;
    it.pz = pz;
    it.drag = drag;
    it.vx = vx;
    it.vy = vy;
    it.vz = vz;
    return it;
  endfunction

  function automatic int flat_cell(int i, int j, int k);
    return (i + GRID_N * (j + GRID_N * k)) & (STORE_DEPTH - 1);
  endfunction

  function automatic int rand_vf();
    case ($urandom_range(9))
      0: return 0;
      1: return 65536;
      2: return $urandom_range(65537, 131071);
      3: return $urandom_range(1, 16);
      default: return $urandom_range(65536);
    endcase
  endfunction

  function automatic int rand_q();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return int'($urandom_range(0, 2097152)) - 1048576;
    endcase
  endfunction

  function automatic longint rand_frac();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return 65535;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // position that lands in cell c on one axis under the current registers
  function automatic logic signed [31:0] pos_for(int axis, longint c);
    longint s, t, p;
    s = longint'(sb.inv[axis]);
    if (s == 0) return $urandom;
    t = c * 65536 - 32768 + rand_frac();
    p = longint'(sb.org[axis]) + (t * 65536 + s - 1) / s;
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
    return p[31:0];
  endfunction

  function automatic int region_cell();
    return flat_cell($urandom_range(4), $urandom_range(4), $urandom_range(4));
  endfunction

  // one input transfer, with bursts and gaps on the sender side
  task automatic push_item(particle_cmd_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    if (it.cmd == CMD_LOAD) geom_ready[it.cidx] = 1;
    cmd <= it.cmd;
    pos_x <= it.px;
    pos_y <= it.py;
    pos_z <= it.pz;
    drag_coef <= it.drag;
    vel_x <= it.vx;
    vel_y <= it.vy;
    vel_z <= it.vz;
    cell_index <= it.cidx;
    vol_frac_in <= it.vf;
    covered_in <= it.cov;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // a deposit only touches cells whose geometry was loaded, so load the missing ones first
  task automatic send_item(particle_cmd_t it);
    int     idx [8];
    longint w [8];
    if (it.cmd == CMD_DEPOSIT && sb.neighbors(it.px, it.py, it.pz, idx, w)) begin
      for (int n = 0; n < 8; n++)
        if (!geom_ready[idx[n]]) push_item(load_item(idx[n], rand_vf(), $urandom_range(4) == 0));
    end
    push_item(it);
  endtask

  // sender pauses until every expected result is back
  task automatic drain(int extra);
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_config(logic [31:0] vals [7]);
    for (int r = 0; r < 7; r++) begin
      cfg_index <= REG_IDX[r];
      cfg_data <= vals[r];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(REG_IDX[r], vals[r]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    particle_cmd_t it;
    logic [31:0]   regs [7];
    int            r;
    int            count;
    int            hi;

    cycle_count <= 0;
    burst_left = 0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cmd <= CMD_LOAD;
    pos_x <= '0;
    pos_y <= '0;
    pos_z <= '0;
    drag_coef <= '0;
    vel_x <= '0;
    vel_y <= '0;
    vel_z <= '0;
    cell_index <= '0;
    vol_frac_in <= '0;
    covered_in <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // register writes are taken during the clearing pass
    regs = '{0, 0, 0, 65536, 65536, 65536, 65536};
    write_config(regs);

    // directed: plain deposit at cell (1,1,1) with the half-cell split
    send_item(deposit_item(65536, 65536, 65536, 65536, 65536, 131072, -196608));
    send_item(cell_item(CMD_READ, 0));
    // volume fraction above 1.0 saturates; covered neighbour gets nothing
    send_item(load_item(flat_cell(1, 1, 1), 131071, 1));
    send_item(deposit_item(65536, 65536, 65536, 65536, 65536, 131072, -196608));
    send_item(cell_item(CMD_READ, flat_cell(1, 1, 1)));
    send_item(cell_item(CMD_READ, 0));
    send_item(cell_item(CMD_CLEAR, 0));
    send_item(cell_item(CMD_READ, 0));
    // off the grid: negative offset, top edge, field extremes
    send_item(deposit_item(-1, 65536, 65536, 65536, 1, 1, 1));
    send_item(deposit_item(65536, 2064384, 65536, 65536, 1, 1, 1));
    send_item(deposit_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 1, 1));
    // zero total weight: all neighbours of cell (3,3,3) empty of fluid
    for (int a = 2; a < 4; a++)
      for (int b = 2; b < 4; b++)
        for (int c = 2; c < 4; c++) send_item(load_item(flat_cell(a, b, c), 0, 0));
    send_item(deposit_item(196608, 196608, 196608, 65536, 65536, 65536, 65536));
    // huge normalized weight: one tiny-weight neighbour holds all the fluid
    for (int a = 0; a < 2; a++)
      for (int b = 0; b < 2; b++)
        for (int c = 0; c < 2; c++)
          send_item(load_item(flat_cell(5 + a, 5 + b, 5 + c), (a && b && !c) ? 1 : 0, 0));
    send_item(deposit_item(6 * 65536 - 32767, 6 * 65536 - 32767, 6 * 65536 - 32768,
                           65536, 32'h7FFF_FFFF, -65536, 12345));
    send_item(cell_item(CMD_READ, flat_cell(5, 5, 5)));
    // saturating drag and velocity
    send_item(deposit_item(131072, 131072, 131072, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 0));
    send_item(cell_item(CMD_READ, flat_cell(2, 2, 2)));
    // top cell index
    send_item(load_item(STORE_DEPTH - 1, 65536, 0));
    send_item(cell_item(CMD_READ, STORE_DEPTH - 1));
    send_item(cell_item(CMD_CLEAR, STORE_DEPTH - 1));

    // random phases, each under its own register setting
    for (int ph = 0; ph < 8; ph++) begin
      drain(8);
      case (ph)
        0: regs = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0};
        1: regs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        default: begin
          for (int a = 0; a < 3; a++) begin
            regs[a] = int'($urandom_range(0, 8388608)) - 4194304;
            case ($urandom_range(3))
              0: regs[a + 3] = 65536;
              1: regs[a + 3] = 32768;
              2: regs[a + 3] = 131072;
              default: regs[a + 3] = $urandom_range(16384, 262144);
            endcase
          end
          case ($urandom_range(6))
            0: regs[6] = 32'hFFFF_FFFF;
            1: regs[6] = 65536;
            default: regs[6] = $urandom_range(1, 1 << 20);
          endcase
        end
      endcase
      write_config(regs);
      count = (ph < 2) ? 30 : 130;
      for (int k = 0; k < count; k++) begin
        if (ph == 4 && k == count / 2) drain(0);
        r = $urandom_range(99);
        it = rand_item();
        if (r < 45) begin
          hi = ($urandom_range(9) == 0) ? GRID_N - 1 : 4;
          it.cmd = CMD_DEPOSIT;
          it.px = pos_for(0, $urandom_range(1, hi));
          it.py = pos_for(1, $urandom_range(1, hi));
          it.pz = pos_for(2, $urandom_range(1, hi));
          it.drag = rand_q();
          it.vx = rand_q();
          it.vy = rand_q();
          it.vz = rand_q();
        end else if (r < 60) begin
          it = load_item(region_cell(), rand_vf(), $urandom_range(4) == 0);
        end else if (r < 82) begin
          it.cmd = CMD_READ;
          if ($urandom_range(4) != 0) it.cidx = STORE_AW'(region_cell());
        end else if (r < 87) begin
          it = cell_item(CMD_CLEAR, region_cell());
        end
        send_item(it);
      end
    end

    drain(20);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
